### hw/rtl/hmlp_pkg.sv
// ---------------------------------------------------------------------------
// hmlp_pkg: shared types and constants
// Codes, table defaults and the FNV-1a constants of the probing hash table.
// ---------------------------------------------------------------------------
package hmlp_pkg;

   localparam int CAPACITY_DEF   = 16;
   localparam int KEY_BYTES_DEF  = 8;
   localparam int VALUE_BITS_DEF = 32;

   localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
   localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
   localparam int LOAD_NUM = 3;
   localparam int LOAD_DEN = 4;

   localparam logic [1:0] OP_PUT    = 2'd0;
   localparam logic [1:0] OP_GET    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_SCAN   = 2'd3;

   localparam logic [1:0] MARK_EMPTY = 2'd0;
   localparam logic [1:0] MARK_LIVE  = 2'd1;
   localparam logic [1:0] MARK_TOMB  = 2'd2;

   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_UPDATED   = 3'd1;
   localparam logic [2:0] ST_FOUND     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_REMOVED   = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;
   localparam logic [2:0] ST_SCAN_END  = 3'd6;

   typedef struct packed {
      logic start;
   } hash_ctl_type;

endpackage

### hw/rtl/hash_map_linear_probing_core.sv
// ---------------------------------------------------------------------------
// hash_map_linear_probing_core: open-addressing table with linear probing
// One beat in, one beat out. The slot store is a single synchronous memory
// read one slot per cycle; a walk reads, compares and writes back.
// ---------------------------------------------------------------------------
// Flow: the hash consumes key bytes up to the first zero byte (at most KEY_BYTES),
//   home slot selection takes the hash modulo CAPACITY (nibble by nibble when
//   CAPACITY is not a power of two), the walk reads and compares each slot visited
//   (up to CAPACITY slots), then the result beat is registered; the write-back rides the compare.
// Throughput: one beat at a time; the next beat is taken the cycle after the
//   result beat leaves.
// Scan visits slots from start_slot upward, reading and checking each in turn.
// Reset: mark flip-flops clear; slot payloads stay undefined.
module hash_map_linear_probing_core #(
   parameter int CAPACITY   = hmlp_pkg::CAPACITY_DEF,
   parameter int KEY_BYTES  = hmlp_pkg::KEY_BYTES_DEF,
   parameter int VALUE_BITS = hmlp_pkg::VALUE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [63:0] req_key,
   input  logic [31:0] req_value,
   input  logic [4:0]  req_start_slot,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_value_out,
   output logic [63:0] rsp_key_out,
   output logic [4:0]  rsp_next_slot,
   output logic [4:0]  rsp_live_count
);
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int VB = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam int MW = 64 + 64 + 32;
   localparam bit POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
   localparam logic [IW+3:0] CAP_W = (IW+4)'(CAPACITY);

   localparam logic [2:0] S_IDLE = 3'd0, S_HASH = 3'd1, S_MOD = 3'd2,
                          S_READ = 3'd3, S_CHECK = 3'd4, S_DONE = 3'd5;

   // slot store: {hash, key, value}; marks live in flip-flops
   logic [MW-1:0] mem [CAPACITY];
   logic [MW-1:0] rd_ff;
   logic [1:0]    mark_ff [CAPACITY];

   logic [2:0]   state_ff, state_in;
   logic [1:0]   op_ff;
   logic [31:0]  val_ff;
   logic [IW:0]  idx_ff, idx_in;
   logic [CW:0]  cnt_ff, cnt_in;
   logic [63:0]  key_ff, h_ff, mod_ff, mod_in;
   logic [IW-1:0] rm_ff, rm_in;
   logic [IW+3:0] rt;
   logic [CW-1:0] live_ff, live_in, used_ff, used_in;
   logic         we;
   logic [IW-1:0] wa;
   logic [MW-1:0] wd;
   logic         mwe;
   logic [1:0]   mwd;

   logic         ov_ff, ov_in;
   logic [2:0]   st_ff, st_in;
   logic [31:0]  vo_ff, vo_in;
   logic [63:0]  ko_ff, ko_in;
   logic [4:0]   ns_ff, ns_in;

   hmlp_pkg::hash_ctl_type hctl;
   logic        hdone;
   logic [63:0] hkey, hval;

   hmlp_hash #(.KEY_BYTES(KEY_BYTES)) u_hash (
      .clock(clock), .reset(reset), .ctl(hctl), .key_raw(req_key),
      .done(hdone), .key_norm(hkey), .hash(hval));

   logic        acc;
   logic [1:0]  cm;
   logic        hit;
   logic [IW-1:0] ci;

   assign req_stall = (state_ff != S_IDLE) || ov_ff;
   assign acc = req_valid && !req_stall;
   assign ci  = idx_ff[IW-1:0];
   assign cm  = mark_ff[ci];
   assign hit = cm == hmlp_pkg::MARK_LIVE && rd_ff[MW-1 -: 64] == h_ff
                && rd_ff[95:32] == key_ff;

   always_comb begin
      state_in = state_ff; idx_in = idx_ff; cnt_in = cnt_ff; mod_in = mod_ff;
      rm_in = rm_ff;
      live_in = live_ff; used_in = used_ff;
      ov_in = ov_ff && rsp_stall;
      st_in = st_ff; vo_in = vo_ff; ko_in = ko_ff; ns_in = ns_ff;
      we = 1'b0; wa = ci; wd = rd_ff; mwe = 1'b0; mwd = hmlp_pkg::MARK_EMPTY;
      hctl.start = 1'b0;
      // one hash nibble into the running remainder, reduced by CAPACITY<<k, high k first
      rt = {rm_ff, mod_ff[63:60]};
      for (int k = 3; k >= 0; k--) begin
         if (rt >= (CAP_W << k)) rt = rt - (CAP_W << k);
      end
      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               if (req_op == hmlp_pkg::OP_SCAN) begin
                  idx_in = {1'b0, req_start_slot[IW-1:0]};
                  if ({27'd0, req_start_slot} >= 32'(CAPACITY)) begin
                     st_in = hmlp_pkg::ST_SCAN_END; vo_in = '0; ko_in = '0;
                     ns_in = 5'(CAPACITY); state_in = S_DONE;
                  end else begin
                     state_in = S_READ;
                  end
               end else begin
                  hctl.start = 1'b1;
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            if (hdone) begin
               mod_in = hval; rm_in = '0; cnt_in = '0; state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (POW2) begin
               idx_in = {1'b0, mod_ff[IW-1:0]}; state_in = S_READ;
            end else begin
               // sixteen nibbles, high first
               rm_in  = rt[IW-1:0];
               mod_in = {mod_ff[59:0], 4'd0};
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == (CW+1)'(15)) begin
                  idx_in = {1'b0, rt[IW-1:0]}; cnt_in = '0; state_in = S_READ;
               end
            end
         end
         S_READ: state_in = S_CHECK;
         S_CHECK: begin
            if (op_ff == hmlp_pkg::OP_SCAN) begin
               if (cm == hmlp_pkg::MARK_LIVE) begin
                  st_in = hmlp_pkg::ST_FOUND; vo_in = rd_ff[31:0];
                  ko_in = rd_ff[95:32]; ns_in = 5'(idx_ff + 1'b1);
                  state_in = S_DONE;
               end else if (32'(idx_ff) + 1 >= CAPACITY) begin
                  st_in = hmlp_pkg::ST_SCAN_END; vo_in = '0; ko_in = '0;
                  ns_in = 5'(CAPACITY); state_in = S_DONE;
               end else begin
                  idx_in = idx_ff + 1'b1; state_in = S_READ;
               end
            end else begin
               vo_in = '0; ko_in = '0; ns_in = '0; state_in = S_DONE;
               if (hit) begin
                  case (op_ff)
                     hmlp_pkg::OP_PUT: begin
                        we = 1'b1; wd = {rd_ff[MW-1:32], val_ff};
                        st_in = hmlp_pkg::ST_UPDATED;
                     end
                     hmlp_pkg::OP_GET: begin
                        st_in = hmlp_pkg::ST_FOUND; vo_in = rd_ff[31:0];
                     end
                     default: begin
                        we = 1'b1; wd = {rd_ff[MW-1 -: 64], 96'd0};
                        mwe = 1'b1; mwd = hmlp_pkg::MARK_TOMB;
                        if (live_ff != '0) live_in = live_ff - 1'b1;
                        st_in = hmlp_pkg::ST_REMOVED;
                     end
                  endcase
               end else if (cm == hmlp_pkg::MARK_EMPTY) begin
                  if (op_ff != hmlp_pkg::OP_PUT) begin
                     st_in = hmlp_pkg::ST_NOT_FOUND;
                  end else if ((32'(used_ff) + 1) * hmlp_pkg::LOAD_DEN >=
                               CAPACITY * hmlp_pkg::LOAD_NUM) begin
                     st_in = hmlp_pkg::ST_FULL;
                  end else begin
                     we = 1'b1; wd = {h_ff, key_ff, val_ff};
                     mwe = 1'b1; mwd = hmlp_pkg::MARK_LIVE;
                     live_in = live_ff + 1'b1; used_in = used_ff + 1'b1;
                     st_in = hmlp_pkg::ST_INSERTED;
                  end
               end else if (32'(cnt_ff) + 1 >= CAPACITY) begin
                  st_in = (op_ff == hmlp_pkg::OP_PUT) ? hmlp_pkg::ST_FULL
                                                      : hmlp_pkg::ST_NOT_FOUND;
               end else begin
                  // advance with wraparound
                  cnt_in = cnt_ff + 1'b1;
                  idx_in = (32'(idx_ff) + 1 >= CAPACITY) ? '0 : idx_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_DONE: begin
            ov_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; ov_ff <= 1'b0; live_ff <= '0; used_ff <= '0;
         for (int i = 0; i < CAPACITY; i++) mark_ff[i] <= hmlp_pkg::MARK_EMPTY;
      end else begin
         state_ff <= state_in; ov_ff <= ov_in; live_ff <= live_in; used_ff <= used_in;
         if (mwe) mark_ff[wa] <= mwd;
      end
      if (acc) begin
         op_ff  <= req_op;
         val_ff <= 32'(req_value[VB-1:0]);
      end
      if (state_ff == S_HASH && hdone) begin
         key_ff <= hkey; h_ff <= hval;
      end
      idx_ff <= idx_in; cnt_ff <= cnt_in; mod_ff <= mod_in; rm_ff <= rm_in;
      st_ff <= st_in; vo_ff <= vo_in; ko_ff <= ko_in; ns_ff <= ns_in;
   end

   // synchronous slot memory, one read port, one write port
   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[idx_in[IW-1:0]];
   end

   assign rsp_valid      = ov_ff;
   assign rsp_status     = st_ff;
   assign rsp_value_out  = vo_ff;
   assign rsp_key_out    = ko_ff;
   assign rsp_next_slot  = ns_ff;
   assign rsp_live_count = 5'(live_ff);
endmodule

### hw/rtl/hmlp_hash.sv
// ---------------------------------------------------------------------------
// hmlp_hash: key normalization and FNV-1a hash
// Consumes one key byte per cycle; the prime multiply is a shift-and-add.
// ---------------------------------------------------------------------------
module hmlp_hash #(
   parameter int KEY_BYTES = hmlp_pkg::KEY_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hmlp_pkg::hash_ctl_type ctl,
   input  logic [63:0]           key_raw,
   output logic                  done,
   output logic [63:0]           key_norm,
   output logic [63:0]           hash
);
   localparam int NB = (KEY_BYTES < 8) ? KEY_BYTES : 8;

   logic [3:0]  pos_ff, pos_in;
   logic        run_ff, run_in;
   logic [63:0] key_ff, key_in, norm_ff, norm_in, h_ff, h_in;
   logic [7:0]  b;
   logic [63:0] hx;

   always_comb begin
      b       = key_ff[8*pos_ff[2:0] +: 8];
      hx      = h_ff ^ {56'd0, b};
      pos_in  = pos_ff;
      run_in  = run_ff;
      key_in  = key_ff;
      norm_in = norm_ff;
      h_in    = h_ff;
      done    = 1'b0;
      if (ctl.start) begin
         run_in  = 1'b1;
         pos_in  = '0;
         key_in  = key_raw;
         norm_in = '0;
         h_in    = hmlp_pkg::FNV_BASIS;
      end else if (run_ff) begin
         if (pos_ff >= 4'(NB) || b == 8'd0) begin
            run_in = 1'b0;
            done   = 1'b1;
         end else begin
            norm_in[8*pos_ff[2:0] +: 8] = b;
            // prime is 2^40 + 0x1b3
            h_in   = (hx << 40) + (hx << 8) + (hx << 7) + (hx << 5) + (hx << 4)
                     + (hx << 1) + hx;
            pos_in = pos_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      pos_ff  <= pos_in;
      key_ff  <= key_in;
      norm_ff <= norm_in;
      h_ff    <= h_in;
   end

   assign key_norm = norm_ff;
   assign hash     = h_ff;
endmodule

### hw/rtl/hmlp_checker.sv
// ---------------------------------------------------------------------------
// hmlp_checker: port-level assertions
// Watches the request stall, the response channel and the live count of the core.
// ---------------------------------------------------------------------------
module hmlp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_status,
   input logic [4:0] rsp_live_count
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("stalled beat changed");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while result pending");
   a_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= hmlp_pkg::ST_SCAN_END)
      else $error("bad status");
   a_ins: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && rsp_status == hmlp_pkg::ST_INSERTED |-> rsp_live_count != 5'd0)
      else $error("insert with zero count");
endmodule

bind hash_map_linear_probing_core hmlp_checker u_hmlp_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
   .rsp_live_count(rsp_live_count));

### tb/tb_hash_map_linear_probing_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_hash_map_linear_probing_core: self-checking bench for the probing table
// Drives put, get, remove and scan beats with bursty idling on both sides.
// Keeps a shadow table that predicts every response beat and compares them.
// ---------------------------------------------------------------------------
module tb_hash_map_linear_probing_core;

   localparam int SLOTS = hmlp_pkg::CAPACITY_DEF;
   localparam int RANDOM_BEATS = 2000;
   localparam int DRAIN_CYCLES = 100;

   typedef struct {
      logic [1:0]  op;
      logic [63:0] key;
      logic [31:0] value;
      logic [4:0]  start_slot;
   } table_req_type;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] value_out;
      logic [63:0] key_out;
      logic [4:0]  next_slot;
      logic [4:0]  live_count;
   } table_rsp_type;

   // Shadow copy of the slot store; predicts one response per request beat.
   class hash_table_scoreboard;
      logic [63:0] shadow_key[SLOTS];
      logic [31:0] shadow_value[SLOTS];
      logic [63:0] shadow_hash[SLOTS];
      logic [1:0]  shadow_mark[SLOTS];
      int          live_entries;
      int          used_slots;
      table_rsp_type expected_q[$];
      int          mismatches;

      function new();
         for (int i = 0; i < SLOTS; i++) shadow_mark[i] = hmlp_pkg::MARK_EMPTY;
         live_entries = 0;
         used_slots   = 0;
         mismatches   = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report_mismatch(input string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         mismatches++;
      endtask

      // Keep bytes up to the first zero byte.
      function logic [63:0] trim_key(input logic [63:0] raw);
         logic [63:0] k;
         k = '0;
         for (int i = 0; i < 8; i++) begin
            if (raw[8*i +: 8] == 8'h00) break;
            k[8*i +: 8] = raw[8*i +: 8];
         end
         return k;
      endfunction

      function logic [63:0] fnv1a(input logic [63:0] k);
         logic [63:0] h;
         h = hmlp_pkg::FNV_BASIS;
         for (int i = 0; i < 8; i++) begin
            if (k[8*i +: 8] == 8'h00) break;
            h = (h ^ {56'd0, k[8*i +: 8]}) * hmlp_pkg::FNV_PRIME;
         end
         return h;
      endfunction

      // Walk from the home slot; return the live match or -1, and the first empty met.
      function int find_slot(input logic [63:0] k, input logic [63:0] h, output int empty_at);
         int idx;
         idx = int'(h % SLOTS);
         empty_at = -1;
         for (int n = 0; n < SLOTS; n++) begin
            if (shadow_mark[idx] == hmlp_pkg::MARK_EMPTY) begin
               empty_at = idx;
               return -1;
            end
            if (shadow_mark[idx] == hmlp_pkg::MARK_LIVE && shadow_hash[idx] == h
                && shadow_key[idx] == k)
               return idx;
            idx = (idx + 1 >= SLOTS) ? 0 : idx + 1;
         end
         return -1;
      endfunction

      function void note_request(input table_req_type r);
         table_rsp_type e;
         logic [63:0] k, h;
         int          hit, empty_at;
         k = trim_key(r.key);
         h = fnv1a(k);
         e = '{status: hmlp_pkg::ST_FOUND, value_out: '0, key_out: '0, next_slot: '0,
               live_count: '0};
         case (r.op)
            hmlp_pkg::OP_PUT: begin
               hit = find_slot(k, h, empty_at);
               if (hit >= 0) begin
                  shadow_value[hit] = r.value;
                  e.status = hmlp_pkg::ST_UPDATED;
               end else if ((used_slots + 1) * hmlp_pkg::LOAD_DEN >= SLOTS * hmlp_pkg::LOAD_NUM
                            || empty_at < 0) begin
                  e.status = hmlp_pkg::ST_FULL;
               end else begin
                  shadow_key[empty_at]   = k;
                  shadow_value[empty_at] = r.value;
                  shadow_hash[empty_at]  = h;
                  shadow_mark[empty_at]  = hmlp_pkg::MARK_LIVE;
                  live_entries++;
                  used_slots++;
                  e.status = hmlp_pkg::ST_INSERTED;
               end
            end
            hmlp_pkg::OP_GET: begin
               hit = find_slot(k, h, empty_at);
               if (hit >= 0) begin
                  e.status    = hmlp_pkg::ST_FOUND;
                  e.value_out = shadow_value[hit];
               end else e.status = hmlp_pkg::ST_NOT_FOUND;
            end
            hmlp_pkg::OP_REMOVE: begin
               hit = find_slot(k, h, empty_at);
               if (hit >= 0) begin
                  shadow_mark[hit]  = hmlp_pkg::MARK_TOMB;
                  shadow_key[hit]   = '0;
                  shadow_value[hit] = '0;
                  if (live_entries > 0) live_entries--;
                  e.status = hmlp_pkg::ST_REMOVED;
               end else e.status = hmlp_pkg::ST_NOT_FOUND;
            end
            default: begin
               e.status    = hmlp_pkg::ST_SCAN_END;
               e.next_slot = 5'(SLOTS);
               for (int i = r.start_slot; i < SLOTS; i++) begin
                  if (shadow_mark[i] == hmlp_pkg::MARK_LIVE) begin
                     e.status    = hmlp_pkg::ST_FOUND;
                     e.value_out = shadow_value[i];
                     e.key_out   = shadow_key[i];
                     e.next_slot = 5'(i + 1);
                     break;
                  end
               end
            end
         endcase
         e.live_count = 5'(live_entries);
         expected_q.push_back(e);
      endfunction

      task check_response(input table_rsp_type got);
         table_rsp_type e;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected response beat, status %0d", got.status));
            return;
         end
         e = expected_q.pop_front();
         if (got.status !== e.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, e.status));
         if (got.value_out !== e.value_out)
            report_mismatch($sformatf("value_out %h, want %h", got.value_out, e.value_out));
         if (got.key_out !== e.key_out)
            report_mismatch($sformatf("key_out %h, want %h", got.key_out, e.key_out));
         if (got.next_slot !== e.next_slot)
            report_mismatch($sformatf("next_slot %0d, want %0d", got.next_slot, e.next_slot));
         if (got.live_count !== e.live_count)
            report_mismatch($sformatf("live_count %0d, want %0d", got.live_count, e.live_count));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_op;
   logic [63:0] req_key;
   logic [31:0] req_value;
   logic [4:0]  req_start_slot;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_value_out;
   logic [63:0] rsp_key_out;
   logic [4:0]  rsp_next_slot;
   logic [4:0]  rsp_live_count;

   hash_table_scoreboard table_sb;
   logic [63:0] key_pool[12];
   int          key_len[12];
   int          burst_left;
   bit          hold_off_req;

   hash_map_linear_probing_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op), .req_key(req_key),
      .req_value(req_value), .req_start_slot(req_start_slot),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_value_out(rsp_value_out), .rsp_key_out(rsp_key_out),
      .rsp_next_slot(rsp_next_slot), .rsp_live_count(rsp_live_count)
   );

   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   // Check every response beat at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         table_sb.check_response('{rsp_status, rsp_value_out, rsp_key_out,
                                   rsp_next_slot, rsp_live_count});
   end

   // Receiver stall pattern: switch mode every so often; honor a long hold-off on request.
   initial begin : rsp_stall_gen
      int mode;
      int left;
      rsp_stall = 1'b0;
      mode = 0;
      left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            // Hold responses back long enough for the core to fill and stall its input.
            for (int n = 0; n < 400; n++) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
            hold_off_req = 1'b0;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(20, 120);
         end
         left--;
         case (mode)
            0: rsp_stall <= 1'b0;                          // no stalls at all
            1: rsp_stall <= ($urandom_range(0, 1) == 0);   // coin flip
            2: rsp_stall <= ($urandom_range(0, 9) != 0);   // mostly stalled
            default: rsp_stall <= ~rsp_stall;              // alternate
         endcase
      end
   end

   // Drive one request beat starting at a falling edge; hold until accepted.
   task automatic send_beat(input table_req_type b);
      req_valid      <= 1'b1;
      req_op         <= b.op;
      req_key        <= b.key;
      req_value      <= b.value;
      req_start_slot <= b.start_slot;
      do @(posedge clock); while (req_stall);
      table_sb.note_request(b);
      @(negedge clock);
   endtask

   // Send with bursty gaps: drop valid for a while at the end of each burst.
   task automatic offer_beat(input table_req_type b);
      send_beat(b);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(0, 12);
      end
   endtask

   // Drop valid and wait until every predicted response has been checked.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (table_sb.pending() > 0) @(negedge clock);
   endtask

   function automatic table_req_type mk_req(input logic [1:0] op, input logic [63:0] key,
                                            input logic [31:0] value,
                                            input logic [4:0] start_slot);
      table_req_type r;
      r.op = op; r.key = key; r.value = value; r.start_slot = start_slot;
      return r;
   endfunction

   // Pick a pooled key and fill the bytes after its terminator with junk.
   function automatic logic [63:0] pool_key();
      int          i;
      logic [63:0] k;
      i = $urandom_range(0, 11);
      k = key_pool[i];
      for (int b = key_len[i] + 1; b < 8; b++) k[8*b +: 8] = 8'($urandom);
      return k;
   endfunction

   function automatic table_req_type random_req();
      logic [63:0] k;
      int          sel;
      k = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : pool_key();
      sel = $urandom_range(0, 9);
      if (sel < 4)      return mk_req(hmlp_pkg::OP_PUT, k, $urandom, 5'($urandom));
      else if (sel < 6) return mk_req(hmlp_pkg::OP_GET, k, $urandom, 5'($urandom));
      else if (sel < 8) return mk_req(hmlp_pkg::OP_REMOVE, k, $urandom, 5'($urandom));
      else              return mk_req(hmlp_pkg::OP_SCAN, k, $urandom,
                                      5'($urandom_range(0, 31)));
   endfunction

   // Run limit: far beyond the slowest legal run.
   initial begin
      #30_000_000;
      $display("[hash_map_linear_probing_core] ERROR");
      $finish;
   end

   initial begin : stimulus
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = hmlp_pkg::OP_PUT;
      req_key        = '0;
      req_value      = '0;
      req_start_slot = '0;
      hold_off_req   = 1'b0;
      burst_left     = 0;
      table_sb       = new();
      // Pool keys: lengths zero through eight, all bytes nonzero.
      for (int i = 0; i < 12; i++) begin
         key_len[i]  = i % 9;
         key_pool[i] = '0;
         for (int b = 0; b < key_len[i]; b++)
            key_pool[i][8*b +: 8] = 8'($urandom_range(1, 255));
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty table, extremes, normalization, tombstones, scan bounds.
      send_beat(mk_req(hmlp_pkg::OP_GET, 64'h0, 32'h0, 5'd0));             // empty table
      send_beat(mk_req(hmlp_pkg::OP_SCAN, 64'h0, 32'h0, 5'd0));            // empty table
      send_beat(mk_req(hmlp_pkg::OP_PUT, 64'h0, 32'hFFFF_FFFF, 5'd31));    // empty-string key
      send_beat(mk_req(hmlp_pkg::OP_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 5'd0)); // 8 bytes
      send_beat(mk_req(hmlp_pkg::OP_PUT, 64'hA5A5_0000_0000_4241, 32'h1234, 5'd0)); // junk
      send_beat(mk_req(hmlp_pkg::OP_GET, 64'h0000_7777_0000_4241, 32'h0, 5'd0)); // other junk
      send_beat(mk_req(hmlp_pkg::OP_PUT, 64'h0000_0000_0000_4241, 32'h5678, 5'd0)); // update
      send_beat(mk_req(hmlp_pkg::OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 5'd0));
      send_beat(mk_req(hmlp_pkg::OP_GET, 64'h0000_0000_0000_00FF, 32'h0, 5'd0)); // missing
      send_beat(mk_req(hmlp_pkg::OP_REMOVE, 64'h0, 32'h0, 5'd0));
      send_beat(mk_req(hmlp_pkg::OP_GET, 64'hFF00_0000_0000_0000, 32'h0, 5'd0)); // removed
      send_beat(mk_req(hmlp_pkg::OP_REMOVE, 64'h0, 32'h0, 5'd0));          // remove twice
      send_beat(mk_req(hmlp_pkg::OP_SCAN, 64'h0, 32'h0, 5'd15));
      send_beat(mk_req(hmlp_pkg::OP_SCAN, 64'h0, 32'h0, 5'd16));           // start at capacity
      send_beat(mk_req(hmlp_pkg::OP_SCAN, 64'h0, 32'h0, 5'd31));           // start past range
      // Fill to the load limit (the last of these keys is refused), then one more new key must be refused.
      for (int i = 1; i <= 9; i++)
         send_beat(mk_req(hmlp_pkg::OP_PUT, 64'(i) * 64'h0101_0101 + 64'h3030_3030,
                          32'(i), 5'd0));
      send_beat(mk_req(hmlp_pkg::OP_PUT, 64'h0000_0000_00DE_ADBE, 32'h0, 5'd0)); // full
      send_beat(mk_req(hmlp_pkg::OP_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hCAFE, 5'd0)); // at limit
      wait_drained();
      @(negedge clock);

      // Random traffic over a small key pool so hits, updates and removes dominate.
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n == 400) hold_off_req = 1'b1;
         if (n == 1200) begin
            wait_drained();
            @(negedge clock);
         end
         offer_beat(random_req());
      end
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (table_sb.mismatches == 0 && table_sb.pending() == 0)
         $display("[hash_map_linear_probing_core] OK");
      else
         $display("[hash_map_linear_probing_core] ERROR");
      $finish;
   end

endmodule
